[rtl/timing_statistics_accumulator_top_assert.svh]
// Assertion macros for the timing statistics accumulator.
`ifndef TIMING_STATISTICS_ACCUMULATOR_TOP_ASSERT_SVH
`define TIMING_STATISTICS_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timing statistics assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timing statistics assertion failed");

`endif

[rtl/tsa_pkg.sv]
// Shared types and constants of the timing statistics accumulator.
`timescale 1ns / 1ps
package tsa_pkg;

    localparam int CNT_W    = 32;
    localparam int TIME_W   = 64;
    localparam int STEP_W   = $clog2(TIME_W);

    typedef enum logic [1:0] {
        OP_ADD_ONE   = 2'd0,
        OP_ADD_BATCH = 2'd1,
        OP_READ_CLR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BATCH_DIV,
        ST_APPLY,
        ST_MEAN_START,
        ST_MEAN_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              upd;
        logic              clr;
        logic [TIME_W-1:0] value;
        logic [CNT_W-1:0]  add_cnt;
        logic [TIME_W-1:0] add_sum;
    } stats_ctl_t;

endpackage

[rtl/timing_statistics_accumulator_top.sv]
// Top level of the timing statistics accumulator: sequencer, shared divider and result register.
`timescale 1ns / 1ps
// The block takes one transaction at a time and answers each with one result
// transaction carrying count, sum, minimum, maximum and truncated mean. An
// add-batch with a nonzero count takes longer than an add-sample, since the
// batch mean and the running mean both pass through the same bit-serial
// divider, which retires one quotient bit per cycle. Read-and-clear and the
// unused code take as long as an add-sample, and any transaction that leaves
// the count at zero skips the mean division. The divider sets the rate, unless
// the result side holds off.
// Results land in an output register, so the next input transaction is taken
// as soon as the previous one has been handed to that register, even if the
// downstream side has not yet taken it. Read-and-clear reports the statistics
// as they stood before the clear; all other operations report them after the
// update. Count wraps modulo 2^32 and sum modulo 2^64.
`include "timing_statistics_accumulator_top_assert.svh"
module timing_statistics_accumulator_top
    import tsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [TIME_W-1:0] time_value,
    input  logic [CNT_W-1:0]  sample_count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CNT_W-1:0]  total_count,
    output logic [TIME_W-1:0] total_sum,
    output logic [TIME_W-1:0] least_time,
    output logic [TIME_W-1:0] greatest_time,
    output logic [TIME_W-1:0] mean_time
);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [TIME_W-1:0] tval_reg, tval_next;
    logic [CNT_W-1:0]  ncnt_reg, ncnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  res_count_reg;
    logic [TIME_W-1:0] res_sum_reg, res_min_reg, res_max_reg, res_mean_reg;

    logic              accept;
    logic              is_batch_in;
    logic              div_start, div_busy, div_done;
    logic [TIME_W-1:0] div_dividend, div_quotient;
    logic [CNT_W-1:0]  div_divisor;
    stats_ctl_t        ctl;
    logic [CNT_W-1:0]  st_count;
    logic [TIME_W-1:0] st_sum, st_min, st_max;
    logic              count_zero;
    logic              out_load;

    assign accept      = in_valid && in_ready;
    assign is_batch_in = (op_t'(operation) == OP_ADD_BATCH) && (sample_count != '0);
    assign count_zero  = (st_count == '0);

    // Hold the transaction fields for the whole run.
    always_comb
    begin
        op_next   = op_reg;
        tval_next = tval_reg;
        ncnt_next = ncnt_reg;
        if (accept)
        begin
            op_next   = op_t'(operation);
            tval_next = time_value;
            ncnt_next = sample_count;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = is_batch_in ? ST_BATCH_DIV : ST_APPLY;
            ST_BATCH_DIV:
                if (div_done)
                    state_next = ST_APPLY;
            ST_APPLY:
                state_next = ST_MEAN_START;
            ST_MEAN_START:
                state_next = count_zero ? ST_FINISH : ST_MEAN_DIV;
            ST_MEAN_DIV:
                if (div_done)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = time_value;
        div_divisor  = sample_count;
        out_load     = 1'b0;
        ctl          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                // launch the batch mean straight from the input port
                div_start = in_valid && is_batch_in;
            end
            ST_APPLY:
            begin
                unique case (op_reg)
                    OP_ADD_ONE:
                    begin
                        ctl.upd     = 1'b1;
                        ctl.value   = tval_reg;
                        ctl.add_cnt = CNT_W'(1);
                        ctl.add_sum = tval_reg;
                    end
                    OP_ADD_BATCH:
                    begin
                        // empty batch leaves the statistics alone
                        ctl.upd     = (ncnt_reg != '0);
                        ctl.value   = div_quotient;
                        ctl.add_cnt = ncnt_reg;
                        ctl.add_sum = tval_reg;
                    end
                    default:
                        ctl.upd = 1'b0;
                endcase
            end
            ST_MEAN_START:
            begin
                div_start    = !count_zero;
                div_dividend = st_sum;
                div_divisor  = st_count;
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || out_ready;
                // clear only once the pre-clear view is captured
                ctl.clr  = out_load && (op_reg == OP_READ_CLR);
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tval_reg <= tval_next;
        ncnt_reg <= ncnt_next;
        if (out_load)
        begin
            res_count_reg <= st_count;
            res_sum_reg   <= st_sum;
            res_min_reg   <= st_min;
            res_max_reg   <= st_max;
            res_mean_reg  <= count_zero ? '0 : div_quotient;
        end
    end

    tsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    tsa_stats u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .count    (st_count),
        .sum      (st_sum),
        .min_time (st_min),
        .max_time (st_max)
    );

    assign out_valid     = out_valid_reg;
    assign total_count   = res_count_reg;
    assign total_sum     = res_sum_reg;
    assign least_time    = res_min_reg;
    assign greatest_time = res_max_reg;
    assign mean_time     = res_mean_reg;

    // Divider must be idle whenever a new transaction can enter.
    `TSA_ASSERT_SAME(a_idle_div_free, in_ready, !div_busy)
    // Divider completion only shows up while the sequencer waits on it.
    `TSA_ASSERT_SAME(a_done_in_wait, div_done,
        (state_reg == ST_BATCH_DIV) || (state_reg == ST_MEAN_DIV))
    // A finished run always presents a result next cycle.
    `TSA_ASSERT_NEXT(a_load_shows, out_load, out_valid)
    // Reported mean is zero whenever the reported count is zero.
    `TSA_ASSERT_SAME(a_zero_mean, out_valid && (total_count == '0), mean_time == '0)

endmodule

[rtl/tsa_div.sv]
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module tsa_div
    import tsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              busy,
    output logic              done,
    output logic [TIME_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    shifted;
    logic [CNT_W+1:0]  diff;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[TIME_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = ~diff[CNT_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, keep the partial remainder below the divisor
            rem_next  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_next  = {quo_reg[TIME_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/tsa_stats.sv]
// Running count, sum, minimum and maximum registers with update and clear.
`timescale 1ns / 1ps
module tsa_stats
    import tsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  stats_ctl_t        ctl,
    output logic [CNT_W-1:0]  count,
    output logic [TIME_W-1:0] sum,
    output logic [TIME_W-1:0] min_time,
    output logic [TIME_W-1:0] max_time
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] sum_reg, sum_next;
    logic [TIME_W-1:0] min_reg, min_next;
    logic [TIME_W-1:0] max_reg, max_next;

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        // clear and update never arrive together; most cycles carry neither
        if (ctl.clr)
        begin
            count_next = '0;
            sum_next   = '0;
            min_next   = '0;
            max_next   = '0;
        end
        else if (ctl.upd)
        begin
            count_next = count_reg + ctl.add_cnt;
            sum_next   = sum_reg + ctl.add_sum;
            // first sample after reset, clear or wrap seeds both extremes
            if (count_reg == '0)
            begin
                min_next = ctl.value;
                max_next = ctl.value;
            end
            else
            begin
                if (ctl.value < min_reg)
                    min_next = ctl.value;
                if (ctl.value > max_reg)
                    max_next = ctl.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    assign count    = count_reg;
    assign sum      = sum_reg;
    assign min_time = min_reg;
    assign max_time = max_reg;

endmodule

[sim/timing_statistics_accumulator_checker.sv]
// Checker for the timing statistics accumulator: tracks the running statistics and compares results.
`timescale 1ns / 1ps
module timing_statistics_accumulator_checker
    import tsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [TIME_W-1:0] time_value,
    input  logic [CNT_W-1:0]  sample_count,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [CNT_W-1:0]  total_count,
    input  logic [TIME_W-1:0] total_sum,
    input  logic [TIME_W-1:0] least_time,
    input  logic [TIME_W-1:0] greatest_time,
    input  logic [TIME_W-1:0] mean_time,
    output int unsigned       fail_count,
    output int unsigned       stats_backlog,
    output int unsigned       results_checked
);

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] sum;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] mean;
    } stats_snapshot_t;

    stats_snapshot_t   stats_expected_q[$];
    logic [CNT_W-1:0]  run_count;
    logic [TIME_W-1:0] run_sum;
    logic [TIME_W-1:0] run_lo;
    logic [TIME_W-1:0] run_hi;

    initial begin
        fail_count      = 0;
        stats_backlog   = 0;
        results_checked = 0;
        run_count       = '0;
        run_sum         = '0;
        run_lo          = '0;
        run_hi          = '0;
    end

    function automatic stats_snapshot_t take_snapshot();
        stats_snapshot_t s;
        s.count = run_count;
        s.sum   = run_sum;
        s.lo    = run_lo;
        s.hi    = run_hi;
        s.mean  = (run_count == '0) ? '0 : run_sum / {{(TIME_W-CNT_W){1'b0}}, run_count};
        return s;
    endfunction

    // An empty accumulator takes the new duration as both extremes.
    task automatic fold_duration(input logic [TIME_W-1:0] dur);
        if (run_count == '0) begin
            run_lo = dur;
            run_hi = dur;
        end else begin
            if (dur < run_lo)
                run_lo = dur;
            if (dur > run_hi)
                run_hi = dur;
        end
    endtask

    task automatic accumulate(input logic [1:0] op, input logic [TIME_W-1:0] t,
                              input logic [CNT_W-1:0] n);
        case (op)
            OP_ADD_ONE: begin
                fold_duration(t);
                run_count = run_count + 1'b1;
                run_sum   = run_sum + t;
                stats_expected_q.push_back(take_snapshot());
            end
            OP_ADD_BATCH: begin
                if (n != '0) begin
                    fold_duration(t / {{(TIME_W-CNT_W){1'b0}}, n});
                    run_count = run_count + n;
                    run_sum   = run_sum + t;
                end
                stats_expected_q.push_back(take_snapshot());
            end
            OP_READ_CLR: begin
                stats_expected_q.push_back(take_snapshot());
                run_count = '0;
                run_sum   = '0;
                run_lo    = '0;
                run_hi    = '0;
            end
            default: begin
                stats_expected_q.push_back(take_snapshot());
            end
        endcase
    endtask

    task automatic compare_result();
        stats_snapshot_t want;
        results_checked++;
        if (stats_expected_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("[%0t] unexpected result: count=%0d sum=%h min=%h max=%h mean=%h",
                         $realtime, total_count, total_sum, least_time, greatest_time,
                         mean_time);
        end else begin
            want = stats_expected_q.pop_front();
            if (want.count !== total_count || want.sum !== total_sum ||
                want.lo !== least_time || want.hi !== greatest_time ||
                want.mean !== mean_time) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("[%0t] result mismatch #%0d", $realtime, results_checked);
                    $display("    expected count=%0d sum=%h min=%h max=%h mean=%h",
                             want.count, want.sum, want.lo, want.hi, want.mean);
                    $display("    actual   count=%0d sum=%h min=%h max=%h mean=%h",
                             total_count, total_sum, least_time, greatest_time, mean_time);
                end
            end
        end
    endtask

    // Compare before accumulating so a stray result never consumes a fresh expectation.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_count = '0;
            run_sum   = '0;
            run_lo    = '0;
            run_hi    = '0;
            stats_expected_q.delete();
        end else begin
            if (out_valid && out_ready)
                compare_result();
            if (in_valid && in_ready)
                accumulate(operation, time_value, sample_count);
        end
        stats_backlog = stats_expected_q.size();
    end

endmodule

[sim/tb_timing_statistics_accumulator_top.sv]
// Testbench top for the timing statistics accumulator: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_timing_statistics_accumulator_top;
    import tsa_pkg::*;

    // The spare operation code is not part of the package enum; name it here.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Leave wide margin for add-batch runs, stalls and the long hold.
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned HOLD_CYCLES  = 2000;
    localparam int unsigned PHASE_ITEMS  = 132;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_ready;
    logic [1:0]        operation     = OP_ADD_ONE;
    logic [TIME_W-1:0] time_value    = '0;
    logic [CNT_W-1:0]  sample_count  = '0;
    logic              out_valid;
    logic              out_ready     = 1'b0;
    logic [CNT_W-1:0]  total_count;
    logic [TIME_W-1:0] total_sum;
    logic [TIME_W-1:0] least_time;
    logic [TIME_W-1:0] greatest_time;
    logic [TIME_W-1:0] mean_time;

    int unsigned fail_count;
    int unsigned stats_backlog;
    int unsigned results_checked;

    // Flow-control knobs, in percent of cycles, changed per phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;

    // Tallies for the closing summary.
    int unsigned sent_add_one = 0;
    int unsigned sent_batch = 0;
    int unsigned sent_empty_batch = 0;
    int unsigned sent_read_clr = 0;
    int unsigned sent_unused = 0;

    timing_statistics_accumulator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .time_value    (time_value),
        .sample_count  (sample_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .total_count   (total_count),
        .total_sum     (total_sum),
        .least_time    (least_time),
        .greatest_time (greatest_time),
        .mean_time     (mean_time)
    );

    timing_statistics_accumulator_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .time_value      (time_value),
        .sample_count    (sample_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .total_count     (total_count),
        .total_sum       (total_sum),
        .least_time      (least_time),
        .greatest_time   (greatest_time),
        .mean_time       (mean_time),
        .fail_count      (fail_count),
        .stats_backlog   (stats_backlog),
        .results_checked (results_checked)
    );

    // 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: abort a run that hangs on a lost handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, stats_backlog);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: stall at random per the current phase, or hold off entirely
    // for a long stretch when asked, so the output register fills and the
    // block backs up into its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    // Offer one transaction and return at the edge where it is accepted.
    // Valid stays high on return; the next call either reloads the payload at
    // once or drops valid for an idle gap first.
    task automatic send_item(input logic [1:0] op, input logic [TIME_W-1:0] t,
                             input logic [CNT_W-1:0] n);
        while ($urandom_range(1, 100) <= send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        time_value   <= t;
        sample_count <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (op)
            OP_ADD_ONE:   sent_add_one++;
            OP_ADD_BATCH:
            begin
                sent_batch++;
                if (n == '0)
                    sent_empty_batch++;
            end
            OP_READ_CLR:  sent_read_clr++;
            default:      sent_unused++;
        endcase
    endtask

    initial
    begin
        int unsigned       pick;
        logic [1:0]        op;
        logic [TIME_W-1:0] t;
        logic [CNT_W-1:0]  n;

        // Hold reset, then release it once for the whole run.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty read, extreme durations, sum wrap, empty batch,
        // the spare code, first sample through a batch, count wrap back to zero
        // followed by a fresh first sample, and a batch at the largest count.
        send_item(OP_READ_CLR,  '0, '0);
        send_item(OP_ADD_ONE,   '0, '0);
        send_item(OP_ADD_ONE,   '1, '0);
        send_item(OP_ADD_ONE,   64'd5, '1);
        send_item(OP_ADD_BATCH, 64'h1234_5678_9abc_def0, '0);
        send_item(OP_UNUSED,    '1, '1);
        send_item(OP_READ_CLR,  '1, '1);
        send_item(OP_ADD_BATCH, '1, 32'd1);
        send_item(OP_ADD_BATCH, 64'hffff_fffe_0000_0001, '1);
        send_item(OP_ADD_ONE,   64'd7, '0);
        send_item(OP_ADD_BATCH, 64'd10, 32'd3);
        send_item(OP_ADD_BATCH, '1, '1);
        send_item(OP_UNUSED,    '0, '0);
        send_item(OP_READ_CLR,  '0, '0);
        send_item(OP_ADD_BATCH, 64'd5, 32'd9);
        send_item(OP_ADD_ONE,   64'h8000_0000_0000_0000, 32'h8000_0000);
        send_item(OP_ADD_BATCH, 64'd100, 32'd2);
        send_item(OP_ADD_ONE,   64'd1, '0);
        send_item(OP_READ_CLR,  '0, '0);
        send_item(OP_ADD_BATCH, '0, 32'd4);
        send_item(OP_READ_CLR,  64'h5555_5555_5555_5555, 32'haaaa_aaaa);

        // Random part in four idling phases; the long hold lands in the first.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_request   = 1'b1;
                end
                1:
                begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 50;
                end
                default:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Weight toward adds, with read-and-clear often enough that the
                // first-sample path keeps coming back.
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    op = OP_ADD_ONE;
                else if (pick < 78)
                    op = OP_ADD_BATCH;
                else if (pick < 92)
                    op = OP_READ_CLR;
                else
                    op = OP_UNUSED;

                case ($urandom_range(0, 5))
                    0: t = TIME_W'($urandom_range(0, 1000));
                    1: t = {$urandom, $urandom};
                    2: t = '1 - TIME_W'($urandom_range(0, 16));
                    3: t = 64'd1 << $urandom_range(0, 63);
                    default: t = {32'd0, $urandom};
                endcase

                case ($urandom_range(0, 4))
                    0: n = '0;
                    1: n = CNT_W'($urandom_range(1, 16));
                    2: n = $urandom;
                    3: n = '1 - CNT_W'($urandom_range(0, 16));
                    default: n = CNT_W'($urandom_range(1, 1000));
                endcase

                send_item(op, t, n);
            end
        end
        in_valid <= 1'b0;

        // Drain: wait for every expected result, then let stragglers show up.
        while (stats_backlog != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d add-sample, %0d add-batch (%0d empty),",
                 sent_add_one, sent_batch, sent_empty_batch);
        $display("  %0d read-and-clear, %0d spare-code; checked %0d results over four phases",
                 sent_read_clr, sent_unused, results_checked);
        if (fail_count == 0 && stats_backlog == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[timing_statistics_accumulator_top.f]
+incdir+rtl
rtl/tsa_pkg.sv
rtl/tsa_div.sv
rtl/tsa_stats.sv
rtl/timing_statistics_accumulator_top.sv
sim/timing_statistics_accumulator_checker.sv
sim/tb_timing_statistics_accumulator_top.sv
